[rtl/core/sws_pkg.sv]
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants of the sliding window sender
// Register indexes, item kind codes, reset values and the structs that pass
// between the configuration block and the window sequencer.
// ----------------------------------------------------------------------------
package sws_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_LAST_SEQ    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    // request kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // reset values
    localparam logic [9:0]  RST_WINDOW_SIZE = 10'd64;
    localparam logic [31:0] RST_LAST_SEQ    = 32'd65535;
    localparam logic [31:0] RST_TIMEOUT     = 32'd23000000;
    localparam logic [31:0] SEQ_ALL_ONES    = 32'hffff_ffff;

    // effective configuration seen by the sequencer
    typedef struct packed {
        logic [9:0]  win;       // window clamped to 1..MAX_WINDOW
        logic [31:0] mask;      // slot mask, 2*win-1
        logic [31:0] last_seq;
        logic [31:0] timeout;
    } t_cfg;

    // one result
    typedef struct packed {
        logic        send_valid;
        logic [31:0] seq;
        logic        is_resend;
        logic        run_done;
        logic        last;
    } t_result;

endpackage

[rtl/core/sws_cfg.sv]
// ----------------------------------------------------------------------------
// sws_cfg: configuration registers
// Holds window size, last sequence and timeout; derives the clamped window
// and the slot mask.
// ----------------------------------------------------------------------------
module sws_cfg #(
    parameter int MAX_WINDOW = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_wdata,
    output sws_pkg::t_cfg  o_cfg
);
    import sws_pkg::*;

    localparam logic [31:0] MAXW = 32'(MAX_WINDOW);

    logic [9:0]  r_window;
    logic [31:0] r_last_seq;
    logic [31:0] r_timeout;
    logic [9:0]  eff_win;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= RST_WINDOW_SIZE;
            r_last_seq <= RST_LAST_SEQ;
            r_timeout  <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_SIZE: r_window   <= i_cfg_wdata[9:0];
                CFG_LAST_SEQ:    r_last_seq <= i_cfg_wdata;
                CFG_TIMEOUT:     r_timeout  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the largest window
    always_comb begin
        if (r_window == 10'd0) begin
            eff_win = 10'd1;
        end else if ({22'd0, r_window} > MAXW) begin
            eff_win = MAXW[9:0];
        end else begin
            eff_win = r_window;
        end
    end

    assign o_cfg.win      = eff_win;
    assign o_cfg.mask     = {21'd0, eff_win, 1'b0} - 32'd1;
    assign o_cfg.last_seq = r_last_seq;
    assign o_cfg.timeout  = r_timeout;

endmodule

[rtl/core/sws_slot_ram.sv]
// ----------------------------------------------------------------------------
// sws_slot_ram: send time store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sws_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sws_ctrl.sv]
// ----------------------------------------------------------------------------
// sws_ctrl: window sequencer
// Clears the slot store after reset, applies acks and walks the slots for a
// poll: advance over acked slots, resend timed-out entries if the window is
// full or all sent, else new sends. Results held one step to mark the last.
// ----------------------------------------------------------------------------
module sws_ctrl #(
    parameter int SLOTS = 1024,
    parameter int AW    = 10,
    parameter int BURST = 32,
    parameter int NW    = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sws_pkg::t_cfg     i_cfg,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_kind,
    input  logic [31:0]       i_ack_seq,
    input  logic [63:0]       i_now,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [63:0]       o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [63:0]       i_mem_rdata,
    output logic              o_res_stb,
    output sws_pkg::t_result  o_res
);
    import sws_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ADV_RD  = 3'd2;
    localparam logic [2:0] ST_ADV_CHK = 3'd3;
    localparam logic [2:0] ST_DECIDE  = 3'd4;
    localparam logic [2:0] ST_RS_RD   = 3'd5;
    localparam logic [2:0] ST_RS_CHK  = 3'd6;
    localparam logic [2:0] ST_SEND    = 3'd7;

    localparam logic [NW-1:0] BURST_N  = NW'(BURST);
    localparam logic [AW-1:0] CLR_LAST = AW'(SLOTS - 1);

    logic [2:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_sent;
    logic [31:0]   r_acked;
    logic          r_fin;
    logic [63:0]   r_now;
    logic [NW-1:0] r_n;
    logic          r_pend_v;
    t_result       r_pend;
    logic          r_out_stb;
    t_result       r_out;

    logic [31:0]   outstanding;
    logic          win_full;
    logic          all_sent;
    logic          all_acked;
    logic          burst_left;
    logic          rs_more;
    logic          can_send;
    logic [31:0]   adv_seq;
    logic [31:0]   rs_seq;
    logic [31:0]   new_seq;
    logic [64:0]   age;
    logic          timed_out;
    t_result       new_res;

    function automatic logic [AW-1:0] slot_of(input logic [31:0] seq,
                                              input logic [31:0] mask);
        logic [31:0] s;
        s = seq & mask;
        return s[AW-1:0];
    endfunction

    // window tests on the current counters
    assign outstanding = r_sent - r_acked;
    assign win_full    = outstanding >= {22'd0, i_cfg.win};
    assign all_sent    = {1'b0, r_sent + 32'd1}  >= ({1'b0, i_cfg.last_seq} + 33'd1);
    assign all_acked   = {1'b0, r_acked + 32'd1} >= ({1'b0, i_cfg.last_seq} + 33'd1);
    assign burst_left  = r_n < BURST_N;
    assign rs_more     = burst_left && (32'(r_n) < outstanding);
    assign can_send    = burst_left && !win_full && !all_sent;

    assign adv_seq = r_acked + 32'd1;
    assign rs_seq  = r_acked + 32'(r_n) + 32'd1;
    assign new_seq = r_sent + 32'd1;

    // timeout: now later than stored time and gap above the limit
    assign age       = {1'b0, r_now} - {1'b0, i_mem_rdata};
    assign timed_out = (i_mem_rdata != 64'd0) && !age[64]
                       && (age[63:0] > {32'd0, i_cfg.timeout});

    // result produced in this cycle, if any
    always_comb begin
        new_res.send_valid = 1'b1;
        new_res.run_done   = 1'b0;
        new_res.last       = 1'b0;
        if (r_state == ST_RS_CHK) begin
            new_res.seq       = rs_seq;
            new_res.is_resend = 1'b1;
        end else begin
            new_res.seq       = new_seq;
            new_res.is_resend = 1'b0;
        end
    end

    // slot store port
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = slot_of(new_seq, i_cfg.mask);
        o_mem_wdata = r_now;
        o_mem_raddr = slot_of(adv_seq, i_cfg.mask);
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                o_mem_wdata = 64'd0;
            end
            ST_IDLE: begin
                if (i_start && i_kind == KIND_ACK) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = slot_of(i_ack_seq, i_cfg.mask);
                    o_mem_wdata = 64'd0;
                end
            end
            ST_RS_RD: begin
                o_mem_raddr = slot_of(rs_seq, i_cfg.mask);
            end
            ST_RS_CHK: begin
                o_mem_we    = timed_out;
                o_mem_waddr = slot_of(rs_seq, i_cfg.mask);
            end
            ST_SEND: begin
                o_mem_we = can_send;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_sent    <= SEQ_ALL_ONES;
            r_acked   <= SEQ_ALL_ONES;
            r_fin     <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_out_stb <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start && i_kind == KIND_POLL) begin
                        r_now    <= i_now;
                        r_n      <= '0;
                        r_pend_v <= 1'b0;
                        r_state  <= ST_ADV_RD;
                    end
                end
                ST_ADV_RD: begin
                    if (r_fin) begin
                        r_out_stb <= 1'b1;
                        r_out     <= '{1'b0, 32'd0, 1'b0, 1'b1, 1'b1};
                        r_state   <= ST_IDLE;
                    end else if (r_acked == r_sent) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_state <= ST_ADV_CHK;
                    end
                end
                ST_ADV_CHK: begin
                    if (i_mem_rdata == 64'd0) begin
                        r_acked <= adv_seq;
                        r_state <= ST_ADV_RD;
                    end else begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (all_acked) begin
                        r_fin     <= 1'b1;
                        r_out_stb <= 1'b1;
                        r_out     <= '{1'b0, 32'd0, 1'b0, 1'b1, 1'b1};
                        r_state   <= ST_IDLE;
                    end else if (win_full || all_sent) begin
                        r_state <= ST_RS_RD;
                    end else begin
                        r_state <= ST_SEND;
                    end
                end
                ST_RS_RD: begin
                    r_state <= rs_more ? ST_RS_CHK : ST_SEND;
                end
                ST_RS_CHK: begin
                    if (timed_out) begin
                        if (r_pend_v) begin
                            r_out_stb <= 1'b1;
                            r_out     <= r_pend;
                        end
                        r_pend   <= new_res;
                        r_pend_v <= 1'b1;
                        r_n      <= r_n + 1'b1;
                        r_state  <= ST_RS_RD;
                    end else begin
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (can_send) begin
                        if (r_pend_v) begin
                            r_out_stb <= 1'b1;
                            r_out     <= r_pend;
                        end
                        r_pend   <= new_res;
                        r_pend_v <= 1'b1;
                        r_sent   <= new_seq;
                        r_n      <= r_n + 1'b1;
                    end else begin
                        // close the poll: held result or a bare status
                        r_out_stb <= 1'b1;
                        if (r_pend_v) begin
                            r_out <= '{r_pend.send_valid, r_pend.seq, r_pend.is_resend,
                                       r_pend.run_done, 1'b1};
                        end else begin
                            r_out <= '{1'b0, 32'd0, 1'b0, 1'b0, 1'b1};
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_res_stb = r_out_stb;
    assign o_res     = r_out;

endmodule

[rtl/core/sliding_window_sender_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_sender_unit: selective-repeat sender window
// Tracks send times per sequence slot and decides sends and resends.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken when start is high and busy is low. i_kind selects an
//   ack (i_ack_seq clears its slot) or a poll (i_now is the current time).
//   An ack completes in the cycle it is taken and gives no result.
//   A poll gives one or more results on o_send_valid, o_seq_out, o_is_resend,
//   o_run_done and o_last_of_poll, each valid for the single cycle in which
//   o_result_stb is high; o_last_of_poll marks the final one of the poll.
//   The receiver has no stall: every strobed result must be taken.
//   While a poll runs, busy is high. The ack advance reads, then checks,
//   each slot that it steps over and stops at a live slot; a decide state
//   then ends the run or picks the resend scan, which reads, then checks,
//   each slot up to the burst or outstanding limit, or the send state for
//   new sends. A poll on a finished run ends at its first read state. The
//   slot store's registered read gives each scan a read and a check state.
//   Each result is held until the next decision; the last one is strobed in
//   the first cycle with busy low.
//   After reset all 2*MAX_WINDOW slot store entries are zeroed, one a cycle,
//   which keeps busy high meanwhile. Configuration writes on i_cfg_we,
//   i_cfg_idx, i_cfg_wdata take effect at once and are taken at any time.
// ----------------------------------------------------------------------------
module sliding_window_sender_unit #(
    parameter int MAX_WINDOW = 512,
    parameter int BURST      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_ack_seq,
    input  logic [63:0] i_now,
    output logic        o_result_stb,
    output logic        o_send_valid,
    output logic [31:0] o_seq_out,
    output logic        o_is_resend,
    output logic        o_run_done,
    output logic        o_last_of_poll
);
    import sws_pkg::*;

    localparam int SLOTS = 2 * MAX_WINDOW;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = $clog2(BURST + 1);

    t_cfg          cfg;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [63:0]   mem_rdata;

    // configuration registers
    sws_cfg #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // send time store
    sws_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // window sequencer
    sws_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .BURST (BURST),
        .NW    (NW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (start),
        .o_busy      (busy),
        .i_kind      (i_kind),
        .i_ack_seq   (i_ack_seq),
        .i_now       (i_now),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_stb   (o_result_stb),
        .o_res       (res)
    );

    assign o_send_valid   = res.send_valid;
    assign o_seq_out      = res.seq;
    assign o_is_resend    = res.is_resend;
    assign o_run_done     = res.run_done;
    assign o_last_of_poll = res.last;

endmodule
